>>> hdl/wsfr_pkg.sv
// shared types and constants for the websocket frame receiver
package wsfr_pkg;

    localparam logic [7:0] START_BYTE = 8'h81;
    localparam logic [7:0] LEN_FIELD  = 8'h7f;
    localparam logic [7:0] MASK_BIT   = 8'h80;
    localparam logic [6:0] LEN_EXT16  = 7'd126;
    localparam logic [6:0] LEN_EXT64  = 7'd127;

    // extended length bytes still due minus one, and the number of mask key bytes
    localparam logic [2:0] EXT16_COUNT = 3'd1;
    localparam logic [2:0] EXT64_COUNT = 3'd7;
    localparam logic [2:0] MASK_BYTES  = 3'd4;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN     = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] payload_byte;
        logic       last;
        logic       empty_frame;
    } result_t;

endpackage

>>> hdl/websocket_frame_receiver.sv
// latency: a payload or empty-frame result is shown the cycle after its byte transfer
// throughput: one byte per cycle; the single output register takes a new result
// in the same cycle its old one is taken, so input stalls only while output stalls
// reset: asynchronous active low, decoder returns to hunting for the start byte,
// length, mask key and output register cleared
module websocket_frame_receiver
    import wsfr_pkg::*;
#(
    parameter int LENGTH_BITS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] payload_byte,
    output logic       last,
    output logic       empty_frame
);

    logic       step;
    result_t    res;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] payload_byte_reg;
    logic       last_reg;
    logic       empty_frame_reg;

    // input transfer when the output register is free or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    wsfr_decoder #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (rx_byte),
        .res     (res)
    );

    // output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = res.valid;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_byte_reg <= 8'd0;
            last_reg         <= 1'b0;
            empty_frame_reg  <= 1'b0;
        end
        else if (step && res.valid)
        begin
            payload_byte_reg <= res.payload_byte;
            last_reg         <= res.last;
            empty_frame_reg  <= res.empty_frame;
        end
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = payload_byte_reg;
    assign last         = last_reg;
    assign empty_frame  = empty_frame_reg;

    // an empty frame result is always marked last with a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_frame |-> last && payload_byte == 8'd0)
        else $error("empty frame result not last or nonzero");

    // a byte that yields a result shows it in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        step && res.valid |=> out_valid)
        else $error("result lost after transfer");

    // input stalls only behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without pending result");

    // a held result that is not taken is not replaced
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(last))
        else $error("pending result changed before transfer");

endmodule

>>> hdl/wsfr_decoder.sv
// frame header parser and payload unmasking state
module wsfr_decoder
    import wsfr_pkg::*;
#(
    parameter int LENGTH_BITS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output result_t    res
);

    phase_t                   phase_reg, phase_next;
    logic [LENGTH_BITS-1:0]   remaining_reg, remaining_next;
    logic [2:0]               hdr_count_reg, hdr_count_next;
    logic [31:0]              mask_key_reg, mask_key_next;
    logic                     masked_reg, masked_next;
    logic [1:0]               position_reg, position_next;

    logic [6:0]               len7;
    logic [LENGTH_BITS-1:0]   ext_len;
    logic [LENGTH_BITS-1:0]   rem_dec;
    logic                     rem_is_one;
    logic [2:0]               mask_count_inc;
    logic [7:0]               key_byte;
    logic                     len_zero;
    logic                     ext_zero;

    // shared datapath terms
    assign len7           = rx_byte[6:0] & LEN_FIELD[6:0];
    assign ext_len        = (remaining_reg[LENGTH_BITS-1 -: 8] != 8'd0)
                            ? {LENGTH_BITS{1'b1}}
                            : {remaining_reg[LENGTH_BITS-9:0], rx_byte};
    assign rem_dec        = remaining_reg - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    assign rem_is_one     = (remaining_reg == {{(LENGTH_BITS-1){1'b0}}, 1'b1});
    assign mask_count_inc = hdr_count_reg + 3'd1;
    assign len_zero       = (len7 == 7'd0);
    assign ext_zero       = (ext_len == '0);

    // mask byte for this payload position, byte 0 in the top bits
    always_comb
    begin
        case (position_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_LEN:
            begin
                if (len7 == LEN_EXT16 || len7 == LEN_EXT64)
                    phase_next = PH_EXTLEN;
                else if (len_zero)
                    phase_next = PH_HUNT;
                else
                    phase_next = (rx_byte & MASK_BIT) != 8'd0 ? PH_MASK : PH_PAYLOAD;
            end
            PH_EXTLEN:
            begin
                if (hdr_count_reg == 3'd0)
                begin
                    if (ext_zero)
                        phase_next = PH_HUNT;
                    else
                        phase_next = masked_reg ? PH_MASK : PH_PAYLOAD;
                end
            end
            PH_MASK:
            begin
                if (mask_count_inc >= MASK_BYTES)
                    phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                if (rem_is_one)
                    phase_next = PH_HUNT;
            end
            default:
                phase_next = (rx_byte == START_BYTE) ? PH_LEN : PH_HUNT;
        endcase
    end

    // datapath updates and result
    always_comb
    begin
        remaining_next = remaining_reg;
        hdr_count_next = hdr_count_reg;
        mask_key_next  = mask_key_reg;
        masked_next    = masked_reg;
        position_next  = position_reg;
        res            = '0;
        case (phase_reg)
            PH_LEN:
            begin
                masked_next   = (rx_byte & MASK_BIT) != 8'd0;
                mask_key_next = '0;
                if (len7 == LEN_EXT16)
                begin
                    remaining_next = '0;
                    hdr_count_next = EXT16_COUNT;
                end
                else if (len7 == LEN_EXT64)
                begin
                    remaining_next = '0;
                    hdr_count_next = EXT64_COUNT;
                end
                else
                begin
                    remaining_next = {{(LENGTH_BITS-7){1'b0}}, len7};
                    if (len_zero)
                    begin
                        res.valid       = 1'b1;
                        res.last        = 1'b1;
                        res.empty_frame = 1'b1;
                    end
                    else
                    begin
                        hdr_count_next = 3'd0;
                        position_next  = 2'd0;
                    end
                end
            end
            PH_EXTLEN:
            begin
                remaining_next = ext_len;
                if (hdr_count_reg == 3'd0)
                begin
                    if (ext_zero)
                    begin
                        res.valid       = 1'b1;
                        res.last        = 1'b1;
                        res.empty_frame = 1'b1;
                    end
                    else
                    begin
                        hdr_count_next = 3'd0;
                        position_next  = 2'd0;
                    end
                end
                else
                    hdr_count_next = hdr_count_reg - 3'd1;
            end
            PH_MASK:
            begin
                mask_key_next  = {mask_key_reg[23:0], rx_byte};
                hdr_count_next = (mask_count_inc >= MASK_BYTES) ? 3'd0 : mask_count_inc;
            end
            PH_PAYLOAD:
            begin
                res.valid        = 1'b1;
                res.payload_byte = rx_byte ^ key_byte;
                res.last         = rem_is_one;
                position_next    = position_reg + 2'd1;
                remaining_next   = rem_dec;
            end
            default:
            begin
            end
        endcase
    end

    // state registers, advanced on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            remaining_reg <= '0;
            hdr_count_reg <= '0;
            mask_key_reg  <= '0;
            masked_reg    <= 1'b0;
            position_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            hdr_count_reg <= hdr_count_next;
            mask_key_reg  <= mask_key_next;
            masked_reg    <= masked_next;
            position_reg  <= position_next;
        end
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench for the websocket frame receiver: directed table, random frames, result scoreboard
module tb_top
    import wsfr_pkg::*;
();

    localparam int LEN_W        = 64;
    localparam int RANDOM_BYTES = 2000;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } frame_out_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       fixed;
        frame_out_t want;
    } stim_row_t;

    localparam frame_out_t NO_RESULT   = '{data: 8'h00, last: 1'b0, empty: 1'b0};
    localparam frame_out_t EMPTY_FRAME = '{data: 8'h00, last: 1'b1, empty: 1'b1};

    // directed stimulus; rows marked fixed carry the result read straight off the frame format
    localparam stim_row_t DIRECTED [25] = '{
        '{8'hff, 1'b0, NO_RESULT},                               // ignored while hunting
        '{8'h81, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, EMPTY_FRAME},                             // unmasked zero length
        '{8'h81, 1'b0, NO_RESULT},
        '{8'h80, 1'b1, EMPTY_FRAME},                             // masked zero length
        '{8'h81, 1'b0, NO_RESULT},                               // mask byte hunted as start
        '{8'h01, 1'b0, NO_RESULT},
        '{8'hff, 1'b1, '{data: 8'hff, last: 1'b1, empty: 1'b0}}, // unmasked passes through
        '{8'h81, 1'b0, NO_RESULT},
        '{8'h81, 1'b0, NO_RESULT},                               // start byte as length byte
        '{8'h81, 1'b0, NO_RESULT},                               // start byte as mask byte
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h81, 1'b1, '{data: 8'h00, last: 1'b1, empty: 1'b0}}, // start byte as payload
        '{8'h81, 1'b0, NO_RESULT},
        '{8'h7e, 1'b0, NO_RESULT},                               // 16-bit extended length
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h02, 1'b0, NO_RESULT},
        '{8'haa, 1'b0, NO_RESULT},
        '{8'h55, 1'b0, NO_RESULT},
        '{8'h81, 1'b0, NO_RESULT},
        '{8'h7e, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, EMPTY_FRAME}                              // extended zero length
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] payload_byte;
    logic       last;
    logic       empty_frame;

    // decoder state mirrored by the testbench
    phase_t           ph       = PH_HUNT;
    logic [LEN_W-1:0] rem_len  = '0;
    logic [2:0]       hdr_cnt  = '0;
    logic [31:0]      mask_key = '0;
    logic             masked   = 1'b0;
    logic [1:0]       pay_pos  = '0;

    frame_out_t due_results[$];
    int         errors      = 0;
    int         frame_bytes = 0;
    int         cycles      = 0;
    bit         calm        = 1'b0;

    websocket_frame_receiver #(.LENGTH_BITS(LEN_W)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .payload_byte (payload_byte),
        .last         (last),
        .empty_frame  (empty_frame)
    );

    always #10 clk = ~clk;

    // length complete: empty frame, or on to mask key or payload
    function automatic bit finish_length(output frame_out_t r);
        r = NO_RESULT;
        if (rem_len == '0)
        begin
            r  = EMPTY_FRAME;
            ph = PH_HUNT;
            return 1'b1;
        end
        hdr_cnt = '0;
        pay_pos = '0;
        ph      = masked ? PH_MASK : PH_PAYLOAD;
        return 1'b0;
    endfunction

    // advance the decoder by one received byte, return 1 when it yields a result
    function automatic bit decode_byte(input logic [7:0] b, output frame_out_t r);
        logic [7:0] key_byte;
        bit         produced;
        r        = NO_RESULT;
        produced = 1'b0;
        case (ph)
            PH_LEN:
            begin
                masked   = b[7];
                mask_key = '0;
                rem_len  = '0;
                if (b[6:0] == LEN_EXT16)
                begin
                    hdr_cnt = EXT16_COUNT;
                    ph      = PH_EXTLEN;
                end
                else if (b[6:0] == LEN_EXT64)
                begin
                    hdr_cnt = EXT64_COUNT;
                    ph      = PH_EXTLEN;
                end
                else
                begin
                    rem_len  = LEN_W'(b[6:0]);
                    produced = finish_length(r);
                end
            end
            PH_EXTLEN:
            begin
                // saturate when the length no longer fits
                if (rem_len[LEN_W-1 -: 8] != 8'h00)
                    rem_len = '1;
                else
                    rem_len = {rem_len[LEN_W-9:0], b};
                if (hdr_cnt == 3'd0)
                    produced = finish_length(r);
                else
                    hdr_cnt = hdr_cnt - 3'd1;
            end
            PH_MASK:
            begin
                mask_key = {mask_key[23:0], b};
                hdr_cnt  = hdr_cnt + 3'd1;
                if (hdr_cnt >= MASK_BYTES)
                begin
                    hdr_cnt = '0;
                    ph      = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                key_byte = mask_key[8 * (3 - int'(pay_pos)) +: 8];
                r.data   = b ^ key_byte;
                pay_pos  = pay_pos + 2'd1;
                rem_len  = rem_len - 1'b1;
                r.last   = (rem_len == '0);
                if (rem_len == '0)
                    ph = PH_HUNT;
                produced = 1'b1;
            end
            default:
            begin
                ph = (b == START_BYTE) ? PH_LEN : PH_HUNT;
            end
        endcase
        return produced;
    endfunction

    // drive one byte, hold it until the transfer, then predict its result
    task automatic send_byte(input logic [7:0] b, input bit use_fixed = 1'b0,
                             input frame_out_t fixed_out = NO_RESULT);
        frame_out_t got;
        bit         produced;
        if (!calm && $urandom_range(0, 99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (ph != PH_HUNT || b == START_BYTE)
            frame_bytes++;
        produced = decode_byte(b, got);
        if (use_fixed)
            due_results.push_back(fixed_out);
        else if (produced)
            due_results.push_back(got);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
    endtask

    // any byte except the start byte, so hunting stays in place
    function automatic logic [7:0] hunt_noise();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == START_BYTE);
        return b;
    endfunction

    // one well-formed final text frame with random content
    task automatic send_frame();
        int          form;
        int          sel;
        int          len;
        logic [63:0] len64;
        logic        want_mask;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            len = 0;
        else if (sel < 80)
            len = $urandom_range(1, 12);
        else if (sel < 95)
            len = $urandom_range(13, 125);
        else
            len = $urandom_range(126, 300);
        form      = $urandom_range(0, 9);
        want_mask = 1'($urandom_range(0, 1));
        len64     = 64'(len);
        send_byte(START_BYTE);
        if (form < 6)
        begin
            if (len > 125)
            begin
                len   = 125;
                len64 = 64'(len);
            end
            send_byte({want_mask, 7'(len)});
        end
        else if (form < 8)
        begin
            send_byte({want_mask, LEN_EXT16});
            send_byte(len64[15:8]);
            send_byte(len64[7:0]);
        end
        else
        begin
            send_byte({want_mask, LEN_EXT64});
            for (int i = 7; i >= 0; i--)
                send_byte(len64[8 * i +: 8]);
        end
        if (len64 == 64'd0)
        begin
            // mask key of an empty frame is hunted through
            if (want_mask && $urandom_range(0, 1) == 1)
                repeat (4) send_byte(hunt_noise());
            return;
        end
        if (want_mask)
            repeat (4) send_byte(8'($urandom_range(0, 255)));
        repeat (int'(len64)) send_byte(8'($urandom_range(0, 255)));
    endtask

    // stimulus sequence
    initial
    begin
        int  sel;
        bit  paused;
        paused = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i].rx, DIRECTED[i].fixed, DIRECTED[i].want);
        drain_results();

        frame_bytes = 0;
        while (frame_bytes < RANDOM_BYTES)
        begin
            calm = (frame_bytes >= 1300 && frame_bytes < 1700);
            if (!paused && frame_bytes >= 1000)
            begin
                drain_results();
                paused = 1'b1;
            end
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                repeat ($urandom_range(1, 3)) send_byte(hunt_noise());
            end
            else if (sel == 1)
            begin
                // doubled start byte turns into a masked one-byte frame
                send_byte(START_BYTE);
                send_byte(START_BYTE);
                repeat (5) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_frame();
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // output stalls, none during the calm stretch
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 13);

    // compare every result transfer with the oldest prediction
    always @(posedge clk)
    begin : check_results
        frame_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual byte %h last %b empty %b",
                         $time, payload_byte, last, empty_frame);
            end
            else
            begin
                want = due_results.pop_front();
                if (payload_byte !== want.data)
                begin
                    errors++;
                    $display("%0t: payload_byte expected %h actual %h",
                             $time, want.data, payload_byte);
                end
                if (last !== want.last)
                begin
                    errors++;
                    $display("%0t: last expected %b actual %b", $time, want.last, last);
                end
                if (empty_frame !== want.empty)
                begin
                    errors++;
                    $display("%0t: empty_frame expected %b actual %b",
                             $time, want.empty, empty_frame);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule

>>> files.f
hdl/wsfr_pkg.sv
hdl/wsfr_decoder.sv
hdl/websocket_frame_receiver.sv
tb/sv/tb_top.sv
